// ===== rtl/wmft_pkg.sv =====
// Shared definitions for the window max frequency tracker.
// Holds default parameters, field widths, request codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package wmft_pkg;

   // Default table sizes
   localparam int KEY_BITS_DEFAULT  = 16;
   localparam int COUNT_MAX_DEFAULT = 1024;

   // Fixed port field widths
   localparam int ITEM_VALUE_WIDTH = 16;
   localparam int MAX_COUNT_WIDTH  = 11;

   // Request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // capture the incoming item, key table read under way
      logic clear;    // clearing sweep step
      logic rd_key;   // key count valid: check, write key table, read populations
      logic upd;      // populations valid: write old-count entry, update maximum
      logic wr_inc;   // write new-count entry, load result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last; // last address of the clearing sweep
      logic req_err;  // item is ignored (valid during rd_key)
   } status_type;

endpackage

// ===== rtl/wmft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the key count table and the count population table copies.
// No dependencies.
`timescale 1ns / 1ps

module wmft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wmft_ctrl.sv =====
// Controller for the window max frequency tracker: sequences the clearing
// sweep and the per-item memory steps. Depends on wmft_pkg.
`timescale 1ns / 1ps

module wmft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  wmft_pkg::status_type status,
   output wmft_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RDK  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_RDK;
            end
         end
         S_RDK: begin
            cmd.rd_key = 1'b1;
            if (status.req_err) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_WR2;
         end
         S_WR2: begin
            cmd.wr_inc   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/wmft_dp.sv =====
// Datapath for the window max frequency tracker: key count table, two
// copies of the count population table, clearing counter, maximum and
// result registers. Depends on wmft_pkg and wmft_ram.
`timescale 1ns / 1ps

module wmft_dp #(
   parameter int KEY_BITS  = wmft_pkg::KEY_BITS_DEFAULT,
   parameter int COUNT_MAX = wmft_pkg::COUNT_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wmft_pkg::cmd_type                     cmd,
   output wmft_pkg::status_type                  status,
   input  logic                                  req_type,
   input  logic [wmft_pkg::ITEM_VALUE_WIDTH-1:0] req_item_value,
   output logic [wmft_pkg::MAX_COUNT_WIDTH-1:0]  rsp_max_count,
   output logic                                  rsp_req_error
);

   localparam int KEY_DEPTH = 1 << KEY_BITS;
   localparam int POP_DEPTH = COUNT_MAX + 1;
   localparam int CW        = $clog2(POP_DEPTH);
   localparam int PW        = KEY_BITS + 1;
   localparam int SWEEP     = (KEY_DEPTH > POP_DEPTH) ? KEY_DEPTH : POP_DEPTH;
   localparam int SW        = $clog2(SWEEP);
   localparam int KEY_EXT   = (KEY_BITS > wmft_pkg::ITEM_VALUE_WIDTH) ?
                              KEY_BITS : wmft_pkg::ITEM_VALUE_WIDTH;
   localparam int MAX_EXT   = (CW > wmft_pkg::MAX_COUNT_WIDTH) ?
                              CW : wmft_pkg::MAX_COUNT_WIDTH;

   logic [KEY_EXT-1:0]  key_ext;
   logic [KEY_BITS-1:0] key_in;
   logic [KEY_BITS-1:0] key_ff;
   logic                type_ff;
   logic [SW-1:0]       clr_ff;
   logic [CW-1:0]       cnt_ff;
   logic [CW-1:0]       nxt_ff;
   logic [PW-1:0]       pop_inc_ff;
   logic [CW-1:0]       max_ff;
   logic [CW-1:0]       max_in;
   logic [CW-1:0]       rsp_max_ff;
   logic                rsp_err_ff;
   logic [MAX_EXT-1:0]  max_wide;

   logic [CW-1:0]       key_rd;
   logic [CW-1:0]       cnt_c;
   logic [CW-1:0]       nxt_c;
   logic                err_c;
   logic [PW-1:0]       pop_old_rd;
   logic [PW-1:0]       pop_new_rd;

   logic                key_we;
   logic [KEY_BITS-1:0] key_waddr;
   logic [CW-1:0]       key_wdata;
   logic                pop_we;
   logic [CW-1:0]       pop_waddr;
   logic [PW-1:0]       pop_wdata;

   // Select the key from the low bits of the item value
   assign key_ext = KEY_EXT'(req_item_value);
   assign key_in  = key_ext[KEY_BITS-1:0];

   // Clamp the stored count, work out the new count and whether to ignore
   always_comb begin
      cnt_c = (key_rd > CW'(COUNT_MAX)) ? CW'(COUNT_MAX) : key_rd;
      if (type_ff == wmft_pkg::REQ_REMOVE) begin
         err_c = (cnt_c == '0);
         nxt_c = cnt_c - CW'(1);
      end else begin
         err_c = (cnt_c >= CW'(COUNT_MAX));
         nxt_c = cnt_c + CW'(1);
      end
   end

   assign status.req_err  = err_c;
   assign status.clr_last = (clr_ff == SW'(SWEEP - 1));

   // Key table write: zero during the sweep, new count once checked
   always_comb begin
      key_we    = cmd.clear | (cmd.rd_key & ~err_c);
      key_waddr = cmd.clear ? clr_ff[KEY_BITS-1:0] : key_ff;
      key_wdata = cmd.clear ? '0 : nxt_c;
   end

   // Population table write: old entry minus one, then new entry plus one
   always_comb begin
      pop_we    = 1'b0;
      pop_waddr = clr_ff[CW-1:0];
      pop_wdata = '0;
      if (cmd.clear) begin
         pop_we = ({1'b0, clr_ff} < (SW+1)'(POP_DEPTH));
      end else if (cmd.upd) begin
         pop_we    = (cnt_ff != '0);
         pop_waddr = cnt_ff;
         pop_wdata = pop_old_rd - PW'(1);
      end else if (cmd.wr_inc) begin
         pop_we    = (nxt_ff != '0);
         pop_waddr = nxt_ff;
         pop_wdata = pop_inc_ff;
      end
   end

   // Raise on insert past the maximum, drop when its last key leaves
   always_comb begin
      max_in = max_ff;
      if (type_ff == wmft_pkg::REQ_REMOVE) begin
         if (max_ff == cnt_ff && pop_old_rd == PW'(1)) begin
            max_in = max_ff - CW'(1);
         end
      end else if (nxt_ff > max_ff) begin
         max_in = nxt_ff;
      end
   end

   wmft_ram #(.WIDTH(CW), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_in),
      .rd_data (key_rd)
   );

   // Two identical copies so both counts are read in the same cycle
   wmft_ram #(.WIDTH(PW), .DEPTH(POP_DEPTH)) u_pop_old_ram (
      .clock   (clock),
      .wr_en   (pop_we),
      .wr_addr (pop_waddr),
      .wr_data (pop_wdata),
      .rd_addr (cnt_c),
      .rd_data (pop_old_rd)
   );

   wmft_ram #(.WIDTH(PW), .DEPTH(POP_DEPTH)) u_pop_new_ram (
      .clock   (clock),
      .wr_en   (pop_we),
      .wr_addr (pop_waddr),
      .wr_data (pop_wdata),
      .rd_addr (nxt_c),
      .rd_data (pop_new_rd)
   );

   // Control state: sweep counter and running maximum
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         max_ff <= '0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + SW'(1);
         end
         if (cmd.upd) begin
            max_ff <= max_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff  <= key_in;
         type_ff <= req_type;
      end
      if (cmd.rd_key) begin
         cnt_ff <= cnt_c;
         nxt_ff <= nxt_c;
      end
      if (cmd.upd) begin
         pop_inc_ff <= pop_new_rd + PW'(1);
      end
      if (cmd.rd_key & err_c) begin
         rsp_max_ff <= max_ff;
         rsp_err_ff <= 1'b1;
      end else if (cmd.wr_inc) begin
         rsp_max_ff <= max_ff;
         rsp_err_ff <= 1'b0;
      end
   end

   // Mask the maximum to the result field
   assign max_wide      = MAX_EXT'(rsp_max_ff);
   assign rsp_max_count = max_wide[wmft_pkg::MAX_COUNT_WIDTH-1:0];
   assign rsp_req_error = rsp_err_ff;

endmodule

// ===== rtl/window_max_frequency_tracker.sv =====
// Top level of the window max frequency tracker: joins the controller and
// the datapath. Depends on wmft_pkg, wmft_ctrl, wmft_dp and wmft_ram.
`timescale 1ns / 1ps

// Usage
// Input channel: an item (req_type, req_item_value) is taken at a rising
// edge with start high and busy low. req_type 0 inserts one occurrence of
// the key, 1 removes one; the key is the low KEY_BITS bits of the value.
// Result channel: rsp_valid is high for one cycle with rsp_max_count (the
// largest occurrence count of any key after the item) and rsp_req_error
// (item ignored: remove of an absent key or insert at COUNT_MAX).
// The receiver cannot stall; each result is on the ports for one cycle.
// Sequence: a normal item runs through the key table read and check, the
// old-count population write and the new-count population write, busy
// high throughout; an ignored item ends at the check. No new item is taken
// while busy; the registered key table read and the two writes through the
// single write port of the population table set how long an item takes.
// A new item may be taken in the cycle its predecessor's result is shown.
// Reset: a clearing pass zeroes both tables, one address a cycle, over
// max(2^KEY_BITS, COUNT_MAX+1) addresses (65536 by default) with busy high.
module window_max_frequency_tracker #(
   parameter int KEY_BITS  = wmft_pkg::KEY_BITS_DEFAULT,
   parameter int COUNT_MAX = wmft_pkg::COUNT_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic [wmft_pkg::ITEM_VALUE_WIDTH-1:0] req_item_value,
   output logic                                  rsp_valid,
   output logic [wmft_pkg::MAX_COUNT_WIDTH-1:0]  rsp_max_count,
   output logic                                  rsp_req_error
);

   wmft_pkg::cmd_type    cmd;
   wmft_pkg::status_type status;

   wmft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   wmft_dp #(.KEY_BITS(KEY_BITS), .COUNT_MAX(COUNT_MAX)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .rsp_max_count  (rsp_max_count),
      .rsp_req_error  (rsp_req_error)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // A result only follows a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy cycle");

   // One result per item: strobes never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");
`endif

endmodule
